// ===== sv/mbr_pkg.sv =====
// Shared types, constants and a helper function for the MSB-first bit reader.
package mbr_pkg;

   localparam int WORD_BITS = 32;
   localparam int MAX_FIELD = 32;
   localparam int BUF_BITS  = 64;
   localparam int FILL_W    = 7;
   localparam int DEBT_W    = 16;
   localparam int COUNT_W   = 16;
   localparam int SHIFT_W   = 6;

   localparam logic [DEBT_W-1:0] DEBT_MAX = {DEBT_W{1'b1}};

   typedef enum logic [1:0] {
      REQ_RESTART = 2'd0,
      REQ_LOAD    = 2'd1,
      REQ_READ    = 2'd2,
      REQ_SKIP    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_UNDERFLOW = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_DEBT_SAT  = 2'd3
   } status_type;

   // Mask with the low n bits set; n of BUF_BITS or more gives all ones.
   function automatic logic [BUF_BITS-1:0] low_mask(input logic [FILL_W-1:0] n);
      logic [BUF_BITS-1:0] m;
      if (n >= FILL_W'(BUF_BITS)) begin
         m = {BUF_BITS{1'b1}};
      end else begin
         m = (BUF_BITS'(1) << n) - BUF_BITS'(1);
      end
      return m;
   endfunction

endpackage

// ===== sv/mbr_if.sv =====
// Request and response channel interfaces of the MSB-first bit reader.
interface mbr_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   req_type;
   logic [mbr_pkg::WORD_BITS-1:0] word;
   logic [mbr_pkg::COUNT_W-1:0]  count;

   modport source (output valid, output req_type, output word, output count, input ready);
   modport sink   (input valid, input req_type, input word, input count, output ready);
endinterface

interface mbr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [31:0]                  value;
   logic [1:0]                   status;
   logic [mbr_pkg::FILL_W-1:0]   bits_held;

   modport source (output valid, output value, output status, output bits_held, input ready);
   modport sink   (input valid, input value, input status, input bits_held, output ready);
endinterface

// ===== sv/msb_first_bit_reader.sv =====
// Top level of the MSB-first bit reader with its 64-bit bit buffer and skip debt.
// A word taken into the input register has its response registered when the result register is free or read.
// Throughput: one request word per cycle while responses are taken; the state update is a single pass
// from the input register through one barrel shift into the result register.
// Reset: synchronous, active high; clears the buffer, fill count, skip debt
// and both pipeline valid flags.
module msb_first_bit_reader (
   input  logic       clock,
   input  logic       reset,
   mbr_req_if.sink    req,
   mbr_rsp_if.source  rsp
);

   logic                            in_valid_ff;
   logic [1:0]                      in_type_ff;
   logic [mbr_pkg::WORD_BITS-1:0]   in_word_ff;
   logic [mbr_pkg::COUNT_W-1:0]     in_count_ff;

   logic [mbr_pkg::BUF_BITS-1:0]    buf_ff, buf_in;
   logic [mbr_pkg::FILL_W-1:0]      fill_ff, fill_in;
   logic [mbr_pkg::DEBT_W-1:0]      debt_ff, debt_in;

   logic                            out_valid_ff;
   logic [31:0]                     out_value_ff, out_value_in;
   mbr_pkg::status_type             out_status_ff, out_status_in;
   logic [mbr_pkg::FILL_W-1:0]      out_held_ff;

   logic advance;
   logic accept;

   logic [mbr_pkg::SHIFT_W-1:0]     drop;
   logic [mbr_pkg::SHIFT_W-1:0]     keep;
   logic [mbr_pkg::SHIFT_W-1:0]     field_n;
   logic [mbr_pkg::FILL_W-1:0]      rd_shift;
   logic [mbr_pkg::BUF_BITS-1:0]    rd_bits;
   logic [mbr_pkg::BUF_BITS-1:0]    ld_bits;
   logic [mbr_pkg::COUNT_W-1:0]     fill_wide;
   logic [mbr_pkg::COUNT_W-1:0]     skip_rest;
   logic [mbr_pkg::DEBT_W:0]        debt_sum;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   assign rsp.valid     = out_valid_ff;
   assign rsp.value     = out_value_ff;
   assign rsp.status    = out_status_ff;
   assign rsp.bits_held = out_held_ff;

   always_comb begin
      buf_in        = buf_ff;
      fill_in       = fill_ff;
      debt_in       = debt_ff;
      out_value_in  = '0;
      out_status_in = mbr_pkg::STAT_OK;

      drop = (debt_ff > mbr_pkg::DEBT_W'(mbr_pkg::WORD_BITS))
           ? mbr_pkg::SHIFT_W'(mbr_pkg::WORD_BITS) : debt_ff[mbr_pkg::SHIFT_W-1:0];
      keep = mbr_pkg::SHIFT_W'(mbr_pkg::WORD_BITS) - drop;
      ld_bits = (buf_ff << keep)
              | ({{(mbr_pkg::BUF_BITS-mbr_pkg::WORD_BITS){1'b0}}, in_word_ff}
                 & mbr_pkg::low_mask(mbr_pkg::FILL_W'(keep)));

      if (in_count_ff == '0) begin
         field_n = mbr_pkg::SHIFT_W'(1);
      end else if (in_count_ff > mbr_pkg::COUNT_W'(mbr_pkg::MAX_FIELD)) begin
         field_n = mbr_pkg::SHIFT_W'(mbr_pkg::MAX_FIELD);
      end else begin
         field_n = in_count_ff[mbr_pkg::SHIFT_W-1:0];
      end
      rd_shift = fill_ff - mbr_pkg::FILL_W'(field_n);
      rd_bits  = (buf_ff >> rd_shift) & mbr_pkg::low_mask(mbr_pkg::FILL_W'(field_n));

      fill_wide = {{(mbr_pkg::COUNT_W-mbr_pkg::FILL_W){1'b0}}, fill_ff};
      skip_rest = in_count_ff - fill_wide;
      debt_sum  = {1'b0, debt_ff} + {1'b0, skip_rest};

      unique case (mbr_pkg::req_kind_type'(in_type_ff))
         mbr_pkg::REQ_RESTART: begin
            buf_in  = '0;
            fill_in = '0;
            debt_in = '0;
         end
         mbr_pkg::REQ_LOAD: begin
            if (fill_ff > mbr_pkg::FILL_W'(mbr_pkg::BUF_BITS - mbr_pkg::WORD_BITS)) begin
               out_status_in = mbr_pkg::STAT_FULL;
            end else begin
               debt_in = debt_ff - mbr_pkg::DEBT_W'(drop);
               buf_in  = ld_bits;
               fill_in = fill_ff + mbr_pkg::FILL_W'(keep);
            end
         end
         mbr_pkg::REQ_READ: begin
            if (fill_ff < mbr_pkg::FILL_W'(field_n)) begin
               out_status_in = mbr_pkg::STAT_UNDERFLOW;
            end else begin
               out_value_in = rd_bits[31:0];
               fill_in      = rd_shift;
               buf_in       = buf_ff & mbr_pkg::low_mask(rd_shift);
            end
         end
         mbr_pkg::REQ_SKIP: begin
            if (in_count_ff <= fill_wide) begin
               fill_in = fill_ff - in_count_ff[mbr_pkg::FILL_W-1:0];
               buf_in  = buf_ff & mbr_pkg::low_mask(fill_in);
            end else begin
               buf_in  = '0;
               fill_in = '0;
               if (debt_sum[mbr_pkg::DEBT_W]) begin
                  debt_in       = mbr_pkg::DEBT_MAX;
                  out_status_in = mbr_pkg::STAT_DEBT_SAT;
               end else begin
                  debt_in = debt_sum[mbr_pkg::DEBT_W-1:0];
               end
            end
         end
         default: begin
            out_status_in = mbr_pkg::STAT_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         buf_ff       <= '0;
         fill_ff      <= '0;
         debt_ff      <= '0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            buf_ff       <= buf_in;
            fill_ff      <= fill_in;
            debt_ff      <= debt_in;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_type_ff  <= req.req_type;
         in_word_ff  <= req.word;
         in_count_ff <= req.count;
      end
      if (advance) begin
         out_value_ff  <= out_value_in;
         out_status_ff <= out_status_in;
         out_held_ff   <= fill_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= mbr_pkg::FILL_W'(mbr_pkg::BUF_BITS))
      else $error("Fill count exceeds the buffer size.");

   a_buf_clean: assert property (@(posedge clock) disable iff (reset)
      (buf_ff & ~mbr_pkg::low_mask(fill_ff)) == '0)
      else $error("Buffer holds bits above the fill count.");

   a_debt_empty: assert property (@(posedge clock) disable iff (reset)
      debt_ff != '0 |-> fill_ff == '0)
      else $error("Skip debt is pending while bits are buffered.");

   a_value_ok: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff != mbr_pkg::STAT_OK |-> out_value_ff == '0)
      else $error("Nonzero value on a response that is not a successful read.");

   a_held_tracks: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_held_ff == fill_ff)
      else $error("Reported bit count differs from the fill count.");
`endif

endmodule
